// ===== rtl/stsc_pkg.sv =====
package stsc_pkg;

    // source size limit and keyword table shape
    localparam int MAX_SOURCE    = 65536;
    localparam int KEYWORD_MAX   = 9;
    localparam int KEYWORD_COUNT = 13;

    // field widths
    localparam int KIND_W  = 6;
    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int POS_W   = 17;
    localparam int WLEN_W  = 4;

    // burst queue shape
    localparam int BURST_MAX   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // offset limits, one bit wider than a position so that p + 1 fits
    localparam logic [POS_W:0] SRC_LIMIT   = (POS_W + 1)'(MAX_SOURCE);
    localparam logic [POS_W:0] START_LIMIT =
        (POS_W + 1)'(((MAX_SOURCE - 1) < 65535) ? (MAX_SOURCE - 1) : 65535);

    // token kinds
    localparam logic [KIND_W-1:0] K_EOF         = 6'd0;
    localparam logic [KIND_W-1:0] K_LEFT_PAREN  = 6'd1;
    localparam logic [KIND_W-1:0] K_RIGHT_PAREN = 6'd2;
    localparam logic [KIND_W-1:0] K_LEFT_BRACE  = 6'd3;
    localparam logic [KIND_W-1:0] K_RIGHT_BRACE = 6'd4;
    localparam logic [KIND_W-1:0] K_SEMICOLON   = 6'd5;
    localparam logic [KIND_W-1:0] K_COMMA       = 6'd6;
    localparam logic [KIND_W-1:0] K_PLUS        = 6'd7;
    localparam logic [KIND_W-1:0] K_MINUS       = 6'd8;
    localparam logic [KIND_W-1:0] K_MULTIPLY    = 6'd9;
    localparam logic [KIND_W-1:0] K_MODULO      = 6'd10;
    localparam logic [KIND_W-1:0] K_DIVIDE      = 6'd11;
    localparam logic [KIND_W-1:0] K_EQUAL_EQUAL = 6'd12;
    localparam logic [KIND_W-1:0] K_ASSIGN      = 6'd13;
    localparam logic [KIND_W-1:0] K_NOT_EQUAL   = 6'd14;
    localparam logic [KIND_W-1:0] K_NOT         = 6'd15;
    localparam logic [KIND_W-1:0] K_GREATER_EQ  = 6'd16;
    localparam logic [KIND_W-1:0] K_INPUT       = 6'd17;
    localparam logic [KIND_W-1:0] K_GREATER     = 6'd18;
    localparam logic [KIND_W-1:0] K_LESS_EQ     = 6'd19;
    localparam logic [KIND_W-1:0] K_LESS        = 6'd20;
    localparam logic [KIND_W-1:0] K_AND         = 6'd21;
    localparam logic [KIND_W-1:0] K_UNKNOWN     = 6'd22;
    localparam logic [KIND_W-1:0] K_OR          = 6'd23;
    localparam logic [KIND_W-1:0] K_NUMBER      = 6'd24;
    localparam logic [KIND_W-1:0] K_STRING      = 6'd25;
    localparam logic [KIND_W-1:0] K_IDENTIFIER  = 6'd39;

    // source characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // keyword table: text right-justified, first character in the highest used byte
    localparam logic [8*KEYWORD_MAX-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        "ghe", "dhake", "nimgi", "jallari", "najallari", "javchvare", "kaam",
        "vishay", "shuru", "jaag", "true", "false", "null"
    };
    localparam logic [WLEN_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd3, 4'd5, 4'd5, 4'd7, 4'd9, 4'd9, 4'd4, 4'd6, 4'd5, 4'd4, 4'd4, 4'd5, 4'd4
    };
    localparam int KW_KIND_FIRST = 26;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_EQ, M_BANG, M_GT, M_LT, M_AMP, M_PIPE,
        M_LINE, M_BLOCK, M_INT, M_DOT, M_FRAC, M_STR, M_IDENT
    } scan_mode_t;

    typedef logic [KEYWORD_MAX-1:0][7:0] word_buf_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } token_t;

    // all tokens caused by one input item
    typedef struct packed {
        logic [1:0]                  count;
        token_t [BURST_MAX-1:0]      tok;
    } burst_t;

    // front to queue
    typedef struct packed {
        logic   valid;
        burst_t burst;
    } push_t;

    // queue to back
    typedef struct packed {
        logic   valid;
        burst_t burst;
    } q_head_t;

    function automatic token_t make_tok(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                                        logic [LEN_W-1:0] length);
        token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        return t;
    endfunction

    // distance between offsets, end clipped to the source limit, zero if not ahead
    function automatic logic [LEN_W-1:0] span(logic [POS_W:0] from, logic [POS_W:0] to);
        logic [POS_W:0] t;
        t = (to > SRC_LIMIT) ? SRC_LIMIT : to;
        if (t <= from) begin
            return '0;
        end
        return LEN_W'(t - from);
    endfunction

    function automatic logic [START_W-1:0] clamp_start(logic [POS_W:0] v);
        return (v > START_LIMIT) ? START_LIMIT[START_W-1:0] : v[START_W-1:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
               (c == CH_UNDER);
    endfunction

    // keyword lookup, only the bytes below the word length are looked at
    function automatic logic [KIND_W-1:0] word_kind(word_buf_t w, logic [WLEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        logic              hit;
        k = K_IDENTIFIER;
        for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
            hit = (len == KW_LEN[i]);
            for (int j = 0; j < KEYWORD_MAX; j++) begin
                if (j < int'(KW_LEN[i])) begin
                    if (w[j] != KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]) begin
                        hit = 1'b0;
                    end
                end
            end
            if (hit) begin
                k = KIND_W'(KW_KIND_FIRST + i);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/stsc_front.sv =====
module stsc_front import stsc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       cmd,
    input  logic [7:0] ch,
    input  logic       q_full,
    output push_t      push
);

    scan_mode_t            mode_reg, mode_next;
    logic                  star_reg, star_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [START_W-1:0]    tb_reg, tb_next;
    logic [WLEN_W-1:0]     wlen_reg, wlen_next;
    word_buf_t             wbuf_reg, wbuf_next;

    logic                  accept;
    logic [POS_W:0]        p_ext;
    logic [POS_W:0]        tb_ext;
    logic [POS_W-1:0]      dot_pos;

    // pending token flush
    logic [1:0]            fin_n;
    token_t                fin_tok0, fin_tok1;

    // fresh byte classification
    scan_mode_t            disp_mode;
    logic                  disp_emit;
    logic [KIND_W-1:0]     disp_kind;
    logic [START_W-1:0]    disp_start;

    // byte consumed by the current mode
    logic                  used;
    logic                  used_emit;
    token_t                used_tok;

    logic                  extra_emit;
    token_t                extra_tok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign p_ext    = {1'b0, pos_reg};
    assign tb_ext   = {2'b0, tb_reg};
    assign dot_pos  = (pos_reg != '0) ? (pos_reg - 1'b1) : '0;
    assign disp_start = clamp_start(p_ext);

    // tokens released when the current mode ends at the present position
    always_comb begin
        fin_n    = 2'd0;
        fin_tok0 = '0;
        fin_tok1 = '0;
        unique case (mode_reg) inside
            M_SLASH: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_DIVIDE, tb_reg, span(tb_ext, p_ext));
            end
            M_EQ: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_ASSIGN, tb_reg, span(tb_ext, p_ext));
            end
            M_BANG: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_NOT, tb_reg, span(tb_ext, p_ext));
            end
            M_GT: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_GREATER, tb_reg, span(tb_ext, p_ext));
            end
            M_LT: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_LESS, tb_reg, span(tb_ext, p_ext));
            end
            M_AMP, M_PIPE: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_UNKNOWN, tb_reg, span(tb_ext, p_ext));
            end
            M_INT, M_FRAC: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_NUMBER, tb_reg, span(tb_ext, p_ext));
            end
            M_DOT: begin
                // number up to the dot, then the dangling dot alone
                fin_n    = 2'd2;
                fin_tok0 = make_tok(K_NUMBER, tb_reg, span(tb_ext, {1'b0, dot_pos}));
                fin_tok1 = make_tok(K_UNKNOWN, clamp_start({1'b0, dot_pos}), LEN_W'(1));
            end
            M_STR: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(K_STRING, clamp_start(tb_ext + 1'b1),
                                    span(tb_ext + 1'b1, p_ext));
            end
            M_IDENT: begin
                fin_n    = 2'd1;
                fin_tok0 = make_tok(word_kind(wbuf_reg, wlen_reg), tb_reg, span(tb_ext, p_ext));
            end
            default: begin
                fin_n = 2'd0;
            end
        endcase
    end

    // classify a byte that starts fresh
    always_comb begin
        disp_mode = M_IDLE;
        disp_emit = 1'b0;
        disp_kind = K_UNKNOWN;
        unique case (ch)
            CH_LPAREN: begin disp_emit = 1'b1; disp_kind = K_LEFT_PAREN;  end
            CH_RPAREN: begin disp_emit = 1'b1; disp_kind = K_RIGHT_PAREN; end
            CH_LBRACE: begin disp_emit = 1'b1; disp_kind = K_LEFT_BRACE;  end
            CH_RBRACE: begin disp_emit = 1'b1; disp_kind = K_RIGHT_BRACE; end
            CH_SEMI:   begin disp_emit = 1'b1; disp_kind = K_SEMICOLON;   end
            CH_COMMA:  begin disp_emit = 1'b1; disp_kind = K_COMMA;       end
            CH_PLUS:   begin disp_emit = 1'b1; disp_kind = K_PLUS;        end
            CH_MINUS:  begin disp_emit = 1'b1; disp_kind = K_MINUS;       end
            CH_STAR:   begin disp_emit = 1'b1; disp_kind = K_MULTIPLY;    end
            CH_PCT:    begin disp_emit = 1'b1; disp_kind = K_MODULO;      end
            CH_SPACE, CH_CR, CH_TAB, CH_LF: begin
                disp_emit = 1'b0;
            end
            CH_SLASH:  disp_mode = M_SLASH;
            CH_EQ:     disp_mode = M_EQ;
            CH_BANG:   disp_mode = M_BANG;
            CH_GT:     disp_mode = M_GT;
            CH_LT:     disp_mode = M_LT;
            CH_AMP:    disp_mode = M_AMP;
            CH_BAR:    disp_mode = M_PIPE;
            CH_QUOTE:  disp_mode = M_STR;
            default: begin
                if (is_digit(ch)) begin
                    disp_mode = M_INT;
                end else if (is_alpha(ch)) begin
                    disp_mode = M_IDENT;
                end else begin
                    disp_emit = 1'b1;
                end
            end
        endcase
    end

    // scanner next state and the burst for this item
    always_comb begin
        mode_next  = mode_reg;
        star_next  = star_reg;
        pos_next   = pos_reg;
        tb_next    = tb_reg;
        wlen_next  = wlen_reg;
        wbuf_next  = wbuf_reg;
        used       = 1'b0;
        used_emit  = 1'b0;
        used_tok   = '0;
        extra_emit = 1'b0;
        extra_tok  = '0;
        push       = '0;

        if (accept) begin
            if (cmd) begin
                // flush, end of file, back to reset state
                extra_emit = 1'b1;
                extra_tok  = make_tok(K_EOF, '0, '0);
                mode_next  = M_IDLE;
                star_next  = 1'b0;
                pos_next   = '0;
                tb_next    = '0;
                wlen_next  = '0;
            end else begin
                unique case (mode_reg) inside
                    M_SLASH: begin
                        if (ch == CH_SLASH) begin
                            mode_next = M_LINE;
                            used      = 1'b1;
                        end else if (ch == CH_STAR) begin
                            mode_next = M_BLOCK;
                            star_next = 1'b0;
                            used      = 1'b1;
                        end
                    end
                    M_EQ, M_BANG, M_LT, M_AMP, M_PIPE, M_GT: begin
                        // two-character operators
                        used_tok.start  = tb_reg;
                        used_tok.length = span(tb_ext, p_ext + 1'b1);
                        if (mode_reg == M_EQ && ch == CH_EQ) begin
                            used = 1'b1; used_tok.kind = K_EQUAL_EQUAL;
                        end else if (mode_reg == M_BANG && ch == CH_EQ) begin
                            used = 1'b1; used_tok.kind = K_NOT_EQUAL;
                        end else if (mode_reg == M_GT && ch == CH_EQ) begin
                            used = 1'b1; used_tok.kind = K_GREATER_EQ;
                        end else if (mode_reg == M_GT && ch == CH_GT) begin
                            used = 1'b1; used_tok.kind = K_INPUT;
                        end else if (mode_reg == M_LT && ch == CH_EQ) begin
                            used = 1'b1; used_tok.kind = K_LESS_EQ;
                        end else if (mode_reg == M_AMP && ch == CH_AMP) begin
                            used = 1'b1; used_tok.kind = K_AND;
                        end else if (mode_reg == M_PIPE && ch == CH_BAR) begin
                            used = 1'b1; used_tok.kind = K_OR;
                        end
                        used_emit = used;
                        if (used) begin
                            mode_next = M_IDLE;
                        end
                    end
                    M_LINE: begin
                        used = 1'b1;
                        if (ch == CH_LF) begin
                            mode_next = M_IDLE;
                        end
                    end
                    M_BLOCK: begin
                        used = 1'b1;
                        if (star_reg && ch == CH_SLASH) begin
                            mode_next = M_IDLE;
                            star_next = 1'b0;
                        end else begin
                            star_next = (ch == CH_STAR);
                        end
                    end
                    M_INT: begin
                        if (is_digit(ch)) begin
                            used = 1'b1;
                        end else if (ch == CH_DOT) begin
                            mode_next = M_DOT;
                            used      = 1'b1;
                        end
                    end
                    M_DOT: begin
                        if (is_digit(ch)) begin
                            mode_next = M_FRAC;
                            used      = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        used = is_digit(ch);
                    end
                    M_STR: begin
                        used = 1'b1;
                        if (ch == CH_QUOTE) begin
                            used_emit = 1'b1;
                            used_tok  = make_tok(K_STRING, clamp_start(tb_ext + 1'b1),
                                                 span(tb_ext + 1'b1, p_ext));
                            mode_next = M_IDLE;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(ch) || is_digit(ch)) begin
                            used = 1'b1;
                            if (wlen_reg < WLEN_W'(KEYWORD_MAX)) begin
                                wbuf_next[wlen_reg] = ch;
                                wlen_next           = wlen_reg + 1'b1;
                            end else begin
                                wlen_next = WLEN_W'(KEYWORD_MAX + 1);
                            end
                        end
                    end
                    default: begin
                        used = 1'b0;
                    end
                endcase

                if (!used) begin
                    // pending token ends here, byte starts fresh
                    extra_emit = disp_emit;
                    extra_tok  = make_tok(disp_kind, disp_start, LEN_W'(1));
                    mode_next  = disp_mode;
                    star_next  = 1'b0;
                    if (disp_mode != M_IDLE) begin
                        tb_next = disp_start;
                    end
                    if (disp_mode == M_IDENT) begin
                        wbuf_next[0] = ch;
                        wlen_next    = WLEN_W'(1);
                    end
                end

                if (pos_reg < POS_W'(MAX_SOURCE)) begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // assemble the burst
            if (used) begin
                push.burst.count  = {1'b0, used_emit};
                push.burst.tok[0] = used_tok;
            end else begin
                push.burst.tok[0]     = fin_tok0;
                push.burst.tok[1]     = fin_tok1;
                push.burst.tok[fin_n] = extra_tok;
                push.burst.count      = fin_n + {1'b0, extra_emit};
            end
            push.valid = (push.burst.count != 2'd0);
        end
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            star_reg <= 1'b0;
            pos_reg  <= '0;
            tb_reg   <= '0;
            wlen_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            star_reg <= star_next;
            pos_reg  <= pos_next;
            tb_reg   <= tb_next;
            wlen_reg <= wlen_next;
        end
    end

    // word characters, valid only below the word length
    always_ff @(posedge aclk) begin
        wbuf_reg <= wbuf_next;
    end

endmodule

// ===== rtl/stsc_queue.sv =====
module stsc_queue import stsc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    burst_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;

    assign full       = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.burst = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push.valid) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push.valid && pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // burst storage
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.burst;
        end
    end

endmodule

// ===== rtl/stsc_back.sv =====
module stsc_back import stsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  q_head_t     head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [39:0] out_data,
    output logic        out_last
);

    logic [1:0] sub_reg, sub_next;
    token_t     tok;
    logic       xfer;

    assign tok       = head.burst.tok[sub_reg];
    assign out_valid = head.valid;
    assign out_last  = (sub_reg == head.burst.count - 1'b1);
    assign out_data  = {1'b0, tok.length, tok.start, tok.kind};
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && out_last;

    // walk through the tokens of the head burst
    always_comb begin
        sub_next = sub_reg;
        if (xfer) begin
            sub_next = out_last ? 2'd0 : (sub_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 2'd0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

// ===== rtl/source_token_scanner_unit.sv =====
// Streaming lexical scanner: source bytes go in on the s_ side, one per transfer
// (tuser high marks end of source), and tokens come out on the m_ side as kind, start
// offset and length, tlast set on the last token caused by an input transfer. An input
// transfer is taken every cycle while the four-entry burst queue between scanner and
// output has room; the scanner itself settles each byte combinationally and registers
// its state. Each token needs one output transfer, so an item that releases two or
// three tokens (end of source, a number ending in a dangling dot, an operator or word
// ended by a symbol) occupies the output for that many transfers and the queue absorbs
// the difference. A released burst is written into the queue and reaches the output
// behind any bursts queued before it. An end-of-source transfer flushes the pending
// token, sends an end-of-file token and restarts offsets at zero.
module source_token_scanner_unit import stsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [5:0] kind, [21:6] lexeme_start, [38:22] lexeme_length
    output logic        m_tlast
);

    push_t   push;
    q_head_t head;
    logic    q_full;
    logic    pop;

    stsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (s_tuser),
        .ch       (s_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    stsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .head    (head)
    );

    stsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // no burst is written into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) push.valid |-> !q_full)
        else $error("burst pushed into full queue");

    // a queued burst always carries at least one token
    assert property (@(posedge aclk) disable iff (!aresetn)
        head.valid |-> (head.burst.count != 2'd0))
        else $error("empty burst in queue");

    // end of source always produces a burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |-> push.valid)
        else $error("end of source without end-of-file token");

    // a burst leaves the queue only with its last token
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (head.valid && m_tlast && m_tready))
        else $error("burst popped before its last token");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import stsc_pkg::*;

    // one token as seen on the result channel
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } tok_rec_t;

    // directed row: a pinned row carries its single token typed in by hand
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       pinned;
        tok_rec_t   tok;
    } dir_row_t;

    localparam int STALL_AT   = 150;
    localparam int STALL_LEN  = 100;
    localparam int CALM_FROM  = 350;
    localparam int CALM_UNTIL = 650;
    localparam int RAND_ITEMS = 280;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    source_token_scanner_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    int unsigned cyc = 0;
    always @(posedge aclk) begin
        cyc <= cyc + 1;
    end

    tok_rec_t   pending_tokens [$];
    int         fail_cnt = 0;
    logic [7:0] src_bytes [$];
    dir_row_t   dir_rows [25];

    string kw_words [KEYWORD_COUNT] = '{
        "ghe", "dhake", "nimgi", "jallari", "najallari", "javchvare", "kaam",
        "vishay", "shuru", "jaag", "true", "false", "null"
    };
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    // scanner state as the predictor tracks it
    scan_mode_t  lx_mode;
    logic        lx_star;
    int unsigned lx_pos;
    int unsigned lx_begin;
    logic [7:0]  lx_word [KEYWORD_MAX];
    int          lx_wlen;

    function automatic logic calm_window();
        return cyc >= CALM_FROM && cyc < CALM_UNTIL;
    endfunction

    function automatic void lex_reset();
        lx_mode  = M_IDLE;
        lx_star  = 1'b0;
        lx_pos   = 0;
        lx_begin = 0;
        lx_wlen  = 0;
    endfunction

    function automatic logic digit_ch(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic word_start_ch(logic [7:0] c);
        return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) || c == CH_UNDER;
    endfunction

    // start offsets stick at the last representable byte
    function automatic logic [START_W-1:0] cap_offset(int unsigned v);
        if (v > MAX_SOURCE - 1) v = MAX_SOURCE - 1;
        if (v > 65535) v = 65535;
        return START_W'(v);
    endfunction

    function automatic logic [LEN_W-1:0] span_len(int unsigned from, int unsigned upto);
        int unsigned d;
        if (upto > MAX_SOURCE) upto = MAX_SOURCE;
        if (upto <= from) return '0;
        d = upto - from;
        if (d > 32'h1FFFF) d = 32'h1FFFF;
        return LEN_W'(d);
    endfunction

    function automatic void add_tok(logic [KIND_W-1:0] kind, logic [START_W-1:0] start,
                                    logic [LEN_W-1:0] length);
        tok_rec_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.last   = 1'b0;
        pending_tokens.push_back(t);
    endfunction

    // keyword lookup over the collected word bytes
    function automatic logic [KIND_W-1:0] word_token();
        logic hit;
        if (lx_wlen > KEYWORD_MAX) return K_IDENTIFIER;
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            hit = (kw_words[k].len() == lx_wlen);
            for (int j = 0; j < lx_wlen; j++) begin
                if (hit && kw_words[k][j] != lx_word[j]) hit = 1'b0;
            end
            if (hit) return KIND_W'(KW_KIND_FIRST + k);
        end
        return K_IDENTIFIER;
    endfunction

    // emit the held token as ended at offset fin, then go idle
    function automatic void flush_pending(int unsigned fin);
        int unsigned d;
        case (lx_mode)
            M_SLASH: add_tok(K_DIVIDE, START_W'(lx_begin), span_len(lx_begin, fin));
            M_EQ:    add_tok(K_ASSIGN, START_W'(lx_begin), span_len(lx_begin, fin));
            M_BANG:  add_tok(K_NOT, START_W'(lx_begin), span_len(lx_begin, fin));
            M_GT:    add_tok(K_GREATER, START_W'(lx_begin), span_len(lx_begin, fin));
            M_LT:    add_tok(K_LESS, START_W'(lx_begin), span_len(lx_begin, fin));
            M_AMP, M_PIPE: add_tok(K_UNKNOWN, START_W'(lx_begin), span_len(lx_begin, fin));
            M_INT, M_FRAC: add_tok(K_NUMBER, START_W'(lx_begin), span_len(lx_begin, fin));
            M_DOT: begin
                // digits then a dot with no digit after it
                d = (fin > 0) ? fin - 1 : 0;
                add_tok(K_NUMBER, START_W'(lx_begin), span_len(lx_begin, d));
                add_tok(K_UNKNOWN, cap_offset(d), LEN_W'(1));
            end
            M_STR: add_tok(K_STRING, cap_offset(lx_begin + 1), span_len(lx_begin + 1, fin));
            M_IDENT: add_tok(word_token(), START_W'(lx_begin), span_len(lx_begin, fin));
            default: ;
        endcase
        lx_mode = M_IDLE;
        lx_star = 1'b0;
    endfunction

    // scan a byte that begins a new token at offset p, mode is idle here
    function automatic void start_token(logic [7:0] c, int unsigned p);
        logic [START_W-1:0] s;
        logic [KIND_W-1:0]  k;
        s = cap_offset(p);
        k = K_UNKNOWN;
        case (c)
            CH_SPACE, CH_CR, CH_TAB, CH_LF: return;
            CH_LPAREN: k = K_LEFT_PAREN;
            CH_RPAREN: k = K_RIGHT_PAREN;
            CH_LBRACE: k = K_LEFT_BRACE;
            CH_RBRACE: k = K_RIGHT_BRACE;
            CH_SEMI:   k = K_SEMICOLON;
            CH_COMMA:  k = K_COMMA;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_MULTIPLY;
            CH_PCT:    k = K_MODULO;
            CH_SLASH:  lx_mode = M_SLASH;
            CH_EQ:     lx_mode = M_EQ;
            CH_BANG:   lx_mode = M_BANG;
            CH_GT:     lx_mode = M_GT;
            CH_LT:     lx_mode = M_LT;
            CH_AMP:    lx_mode = M_AMP;
            CH_BAR:    lx_mode = M_PIPE;
            CH_QUOTE:  lx_mode = M_STR;
            default: begin
                if (digit_ch(c)) begin
                    lx_mode = M_INT;
                end else if (word_start_ch(c)) begin
                    lx_mode    = M_IDENT;
                    lx_word[0] = c;
                    lx_wlen    = 1;
                end
            end
        endcase
        if (lx_mode != M_IDLE) lx_begin = s;
        else add_tok(k, s, LEN_W'(1));
    endfunction

    function automatic logic close_pair(logic [7:0] c, logic [7:0] want, logic [KIND_W-1:0] kind,
                                        int unsigned p);
        if (c != want) return 1'b0;
        add_tok(kind, START_W'(lx_begin), span_len(lx_begin, p + 1));
        lx_mode = M_IDLE;
        return 1'b1;
    endfunction

    // predict the tokens released by one input transfer
    function automatic void lex_byte(logic cmd, logic [7:0] c);
        int unsigned p;
        int          n0;
        logic        took;
        p    = lx_pos;
        n0   = pending_tokens.size();
        took = 1'b0;
        if (cmd) begin
            flush_pending(p);
            add_tok(K_EOF, '0, '0);
            lex_reset();
        end else begin
            case (lx_mode)
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        lx_mode = M_LINE;
                        took    = 1'b1;
                    end else if (c == CH_STAR) begin
                        lx_mode = M_BLOCK;
                        lx_star = 1'b0;
                        took    = 1'b1;
                    end
                end
                M_EQ:   took = close_pair(c, CH_EQ, K_EQUAL_EQUAL, p);
                M_BANG: took = close_pair(c, CH_EQ, K_NOT_EQUAL, p);
                M_GT: begin
                    took = close_pair(c, CH_EQ, K_GREATER_EQ, p);
                    if (!took) took = close_pair(c, CH_GT, K_INPUT, p);
                end
                M_LT:   took = close_pair(c, CH_EQ, K_LESS_EQ, p);
                M_AMP:  took = close_pair(c, CH_AMP, K_AND, p);
                M_PIPE: took = close_pair(c, CH_BAR, K_OR, p);
                M_LINE: begin
                    if (c == CH_LF) lx_mode = M_IDLE;
                    took = 1'b1;
                end
                M_BLOCK: begin
                    if (lx_star && c == CH_SLASH) begin
                        lx_mode = M_IDLE;
                        lx_star = 1'b0;
                    end else begin
                        lx_star = (c == CH_STAR);
                    end
                    took = 1'b1;
                end
                M_INT: begin
                    if (digit_ch(c)) begin
                        took = 1'b1;
                    end else if (c == CH_DOT) begin
                        lx_mode = M_DOT;
                        took    = 1'b1;
                    end
                end
                M_DOT: begin
                    if (digit_ch(c)) begin
                        lx_mode = M_FRAC;
                        took    = 1'b1;
                    end
                end
                M_FRAC: took = digit_ch(c);
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        add_tok(K_STRING, cap_offset(lx_begin + 1), span_len(lx_begin + 1, p));
                        lx_mode = M_IDLE;
                    end
                    took = 1'b1;
                end
                M_IDENT: begin
                    if (word_start_ch(c) || digit_ch(c)) begin
                        if (lx_wlen < KEYWORD_MAX) begin
                            lx_word[lx_wlen] = c;
                            lx_wlen++;
                        end else begin
                            lx_wlen = KEYWORD_MAX + 1;
                        end
                        took = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!took) begin
                flush_pending(p);
                start_token(c, p);
            end
            if (lx_pos < MAX_SOURCE) lx_pos++;
        end
        if (pending_tokens.size() > n0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
    endfunction

    // offer one item, wait for its transfer, then predict its tokens
    task automatic feed(input logic cmd, input logic [7:0] ch, input logic pinned = 1'b0,
                        input tok_rec_t typed = '0);
        int n0;
        while (!calm_window() && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n0 = pending_tokens.size();
        lex_byte(cmd, ch);
        if (pinned) begin
            while (pending_tokens.size() > n0) void'(pending_tokens.pop_back());
            pending_tokens.push_back(typed);
        end
    endtask

    // hold the input until every predicted token has been seen
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_tokens.size() != 0);
    endtask

    function automatic dir_row_t drow(logic cmd, logic [7:0] ch, logic pinned = 1'b0,
                                      logic [KIND_W-1:0] kind = K_EOF,
                                      int unsigned start = 0, int unsigned length = 0);
        dir_row_t r;
        r.cmd        = cmd;
        r.ch         = ch;
        r.pinned     = pinned;
        r.tok.kind   = kind;
        r.tok.start  = START_W'(start);
        r.tok.length = LEN_W'(length);
        r.tok.last   = 1'b1;
        return r;
    endfunction

    // append one well-formed (or deliberately broken) piece of source text
    task automatic add_piece();
        string      ops2   = "==!=>=>><=&&||";
        string      ops1   = "=!<>/&|";
        string      punct  = "(){};,+-*%";
        string      spaces = " \t\r\n";
        string      kw;
        int         sel;
        int         n;
        int         idx;
        logic [7:0] b;
        sel = $urandom_range(0, 13);
        case (sel)
            0, 11: begin
                kw = kw_words[$urandom_range(0, KEYWORD_COUNT - 1)];
                for (int i = 0; i < kw.len(); i++) src_bytes.push_back(kw[i]);
                if ($urandom_range(3) == 0) src_bytes.push_back(word_chars[$urandom_range(0, 62)]);
            end
            1, 12: begin
                n = $urandom_range(1, 12);
                src_bytes.push_back(word_chars[$urandom_range(0, 52)]);
                for (int i = 1; i < n; i++) src_bytes.push_back(word_chars[$urandom_range(0, 62)]);
            end
            2, 13: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) src_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(1) == 1) begin
                    src_bytes.push_back(CH_DOT);
                    n = $urandom_range(0, 3);
                    for (int i = 0; i < n; i++) begin
                        src_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
            end
            3: begin
                src_bytes.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_QUOTE) b = 8'h00;
                    src_bytes.push_back(b);
                end
                if ($urandom_range(4) != 0) src_bytes.push_back(CH_QUOTE);
            end
            4: begin
                src_bytes.push_back(CH_SLASH);
                src_bytes.push_back(CH_SLASH);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) src_bytes.push_back(8'($urandom_range(0, 255)));
                src_bytes.push_back(CH_LF);
            end
            5: begin
                src_bytes.push_back(CH_SLASH);
                src_bytes.push_back(CH_STAR);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 2))
                        0:       src_bytes.push_back(CH_STAR);
                        1:       src_bytes.push_back(CH_SLASH);
                        default: src_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                src_bytes.push_back(CH_STAR);
                src_bytes.push_back(CH_SLASH);
            end
            6: begin
                idx = $urandom_range(0, 6);
                src_bytes.push_back(ops2[2 * idx]);
                src_bytes.push_back(ops2[2 * idx + 1]);
            end
            7: src_bytes.push_back(ops1[$urandom_range(0, 6)]);
            8: src_bytes.push_back(punct[$urandom_range(0, 9)]);
            9: src_bytes.push_back(spaces[$urandom_range(0, 3)]);
            default: src_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(1) == 1) src_bytes.push_back(spaces[$urandom_range(0, 3)]);
    endtask

    // result channel ready, with one long hold-off to back up the block
    int unsigned rx_cycles = 0;
    always @(posedge aclk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles >= STALL_AT && rx_cycles < STALL_AT + STALL_LEN) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm_window() || ($urandom_range(99) >= 11);
        end
    end

    // compare every result transfer with the oldest predicted token
    always @(posedge aclk) begin
        tok_rec_t got;
        tok_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tdata[5:0];
            got.start  = m_tdata[21:6];
            got.length = m_tdata[38:22];
            got.last   = m_tlast;
            if (pending_tokens.size() == 0) begin
                if (fail_cnt < 10) begin
                    $display("%0t: unexpected token kind=%0d start=%0d len=%0d last=%0b",
                             $realtime, got.kind, got.start, got.length, got.last);
                end
                fail_cnt++;
            end else begin
                want = pending_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.last !== want.last) begin
                    if (fail_cnt < 10) begin
                        $display("%0t: token mismatch exp kind=%0d start=%0d len=%0d last=%0b",
                                 $realtime, want.kind, want.start, want.length, want.last);
                        $display("%0t:                got kind=%0d start=%0d len=%0d last=%0b",
                                 $realtime, got.kind, got.start, got.length, got.last);
                    end
                    fail_cnt++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int rnd_items;
        rnd_items = 0;
        lex_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // operators, odd bytes, dangling dot, unterminated comment and string, keyword
        dir_rows = '{
            drow(1'b0, CH_LPAREN, 1'b1, K_LEFT_PAREN, 0, 1),
            drow(1'b0, 8'h00, 1'b1, K_UNKNOWN, 1, 1),
            drow(1'b0, 8'hFF, 1'b1, K_UNKNOWN, 2, 1),
            drow(1'b0, CH_AMP),
            drow(1'b0, CH_SPACE, 1'b1, K_UNKNOWN, 3, 1),
            drow(1'b0, CH_BAR),
            drow(1'b0, CH_BAR),
            drow(1'b0, CH_ZERO + 8'd7),
            drow(1'b0, CH_DOT),
            drow(1'b0, CH_GT),
            drow(1'b0, CH_GT),
            drow(1'b0, CH_QUOTE),
            drow(1'b0, 8'h00),
            drow(1'b0, CH_QUOTE),
            drow(1'b0, CH_SLASH),
            drow(1'b0, CH_STAR),
            drow(1'b0, 8'h00),
            drow(1'b1, 8'hFF, 1'b1, K_EOF, 0, 0),
            drow(1'b0, CH_QUOTE),
            drow(1'b0, "x"),
            drow(1'b1, 8'h00),
            drow(1'b0, "g"),
            drow(1'b0, "h"),
            drow(1'b0, "e"),
            drow(1'b1, 8'h5A)
        };
        foreach (dir_rows[i]) begin
            feed(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].pinned, dir_rows[i].tok);
        end
        wait_idle();

        // random sources built from token-shaped pieces, each closed by an end item
        while (rnd_items < RAND_ITEMS) begin
            src_bytes.delete();
            repeat ($urandom_range(3, 14)) add_piece();
            foreach (src_bytes[i]) feed(1'b0, src_bytes[i]);
            feed(1'b1, 8'($urandom_range(0, 255)));
            rnd_items += src_bytes.size() + 1;
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stsc_pkg.sv
rtl/stsc_front.sv
rtl/stsc_queue.sv
rtl/stsc_back.sv
rtl/source_token_scanner_unit.sv
verif/tb_top.sv
